// ===== hdl/ffha_pkg.sv =====
// Shared types and constants for the first-fit heap allocator core.
// No dependencies; imported by the core.
package ffha_pkg;

   localparam int HEAP_GRANULES   = 4096;
   localparam int GRANULE_SHIFT   = 4;
   localparam int HEADER_GRANULES = 2;
   localparam int ADDR_W          = 12;
   localparam int GRAN_W          = 13;

   localparam logic       KIND_ALLOC   = 1'b0;
   localparam logic       KIND_RELEASE = 1'b1;

   localparam logic [1:0] ST_DONE = 2'd0;
   localparam logic [1:0] ST_OOM  = 2'd1;
   localparam logic [1:0] ST_NULL = 2'd2;

   localparam logic [1:0] CSR_GROWTH_FLOOR = 2'd0;
   localparam logic [1:0] CSR_LIMIT        = 2'd1;

   typedef struct packed {
      logic [0:0]  kind;
      logic [16:0] request_bytes;
      logic [15:0] release_offset;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] payload_offset;
   } rsp_type;

   // Block header: payload size in granules, free mark, predecessor start
   typedef struct packed {
      logic [GRAN_W-1:0] size;
      logic              free;
      logic [ADDR_W-1:0] prev;
   } hdr_type;

endpackage

// ===== hdl/first_fit_heap_allocator_core.sv =====
// First-fit heap allocator: sequencer over a header RAM with split and coalesce.
// Depends on ffha_pkg and ffha_ram.
//
//  channel | ports                      | handshake
//  --------+----------------------------+------------------------------
//  request | start, busy, req           | accepted when start && !busy
//  result  | rsp_strobe, rsp            | one-cycle strobe, no stall
//  config  | csr_valid/ready/index/data | written when valid && ready
//
// Allocate holds busy while it walks the headers, one read per block, then takes
// a block or reports out of memory; release holds busy while it walks, then
// marks and coalesces. A zero-size or malformed request never raises busy.
// The walk is set by the single header RAM port: one read per block.
// Reset clears the heap (end zero); the header RAM needs no clearing pass.
// The result strobe comes in the cycle busy drops; the receiver cannot stall.
module first_fit_heap_allocator_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ffha_pkg::req_type req,
   output logic             rsp_strobe,
   output ffha_pkg::rsp_type rsp,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [12:0]      csr_data
);
   import ffha_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_GROW, S_TAKE, S_SPLIT_RDN, S_SPLIT_WRN,
      S_TAKE_WR, S_REL_RD, S_REL_CHK, S_REL_MARK, S_M_RDB, S_M_GETB, S_M_RDN,
      S_M_GETN, S_M_RDN2, S_M_GETN2, S_M_DONE, S_P_RD, S_P_CHK
   } state_type;

   state_type         state_ff;
   logic              phase_ff, split_ff;
   logic [GRAN_W-1:0] heap_end_ff, growth_floor_ff, limit_ff;
   logic [13:0]       need_ff;
   logic [13:0]       g_ff, nx_ff;
   logic [ADDR_W-1:0] at_ff, tgt_ff, b_ff, last_ff;
   hdr_type           cur_ff, bhdr_ff;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr, ram_raddr;
   hdr_type           ram_wdata, ram_rdata;
   logic [ADDR_W-1:0] rest;
   logic [GRAN_W-1:0] merged_size, limit_eff;
   logic [13:0]       need_in, want;
   logic [11:0]       rel_gran;

   ffha_ram #(.WIDTH($bits(hdr_type)), .DEPTH(HEAP_GRANULES)) u_hdr_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   // Shared address arithmetic
   always_comb begin
      rest        = ADDR_W'(at_ff + ADDR_W'(HEADER_GRANULES) + need_ff[ADDR_W-1:0]);
      merged_size = GRAN_W'(bhdr_ff.size + GRAN_W'(HEADER_GRANULES) + ram_rdata.size);
      limit_eff   = (limit_ff > GRAN_W'(HEAP_GRANULES)) ? GRAN_W'(HEAP_GRANULES) : limit_ff;
      want        = need_ff + 14'(HEADER_GRANULES);
      if (want < 14'(growth_floor_ff)) begin
         want = 14'(growth_floor_ff);
      end
      need_in  = 14'((18'(req.request_bytes) + 18'd15) >> GRANULE_SHIFT);
      rel_gran = req.release_offset[15:GRANULE_SHIFT];
   end

   // Drive header RAM ports from the sequencer
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = at_ff;
      ram_wdata = cur_ff;
      ram_raddr = g_ff[ADDR_W-1:0];
      unique case (state_ff)
         S_TAKE: begin
            if (14'(cur_ff.size) >= need_ff + 14'(HEADER_GRANULES + 1)) begin
               ram_we    = 1'b1;
               ram_waddr = rest;
               ram_wdata = '{size: GRAN_W'(14'(cur_ff.size) - need_ff
                                           - 14'(HEADER_GRANULES)),
                             free: 1'b1, prev: at_ff};
            end
         end
         S_SPLIT_RDN: ram_raddr = nx_ff[ADDR_W-1:0];
         S_SPLIT_WRN: begin
            ram_we    = 1'b1;
            ram_waddr = nx_ff[ADDR_W-1:0];
            ram_wdata = '{size: ram_rdata.size, free: ram_rdata.free, prev: rest};
         end
         S_TAKE_WR: begin
            ram_we    = 1'b1;
            ram_wdata = '{size: split_ff ? GRAN_W'(need_ff) : cur_ff.size, free: 1'b0,
                          prev: cur_ff.prev};
         end
         S_REL_MARK: begin
            ram_we    = 1'b1;
            ram_waddr = tgt_ff;
            ram_wdata = '{size: cur_ff.size, free: 1'b1, prev: cur_ff.prev};
         end
         S_M_RDB: ram_raddr = b_ff;
         S_M_RDN, S_M_RDN2: ram_raddr = nx_ff[ADDR_W-1:0];
         S_M_GETN: begin
            ram_we    = ram_rdata.free;
            ram_waddr = b_ff;
            ram_wdata = '{size: merged_size, free: bhdr_ff.free, prev: bhdr_ff.prev};
         end
         S_M_GETN2: begin
            ram_we    = 1'b1;
            ram_waddr = nx_ff[ADDR_W-1:0];
            ram_wdata = '{size: ram_rdata.size, free: ram_rdata.free, prev: b_ff};
         end
         S_P_RD: ram_raddr = cur_ff.prev;
         default: ;
      endcase
   end

   // Sequencer, heap bookkeeping, config registers and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         heap_end_ff     <= '0;
         last_ff         <= '0;
         growth_floor_ff <= GRAN_W'(1024);
         limit_ff        <= GRAN_W'(4096);
         rsp_strobe      <= 1'b0;
         rsp             <= '0;
      end else begin
         rsp_strobe <= 1'b0;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_GROWTH_FLOOR: growth_floor_ff <= csr_data;
               CSR_LIMIT:        limit_ff        <= csr_data;
               default: ;
            endcase
         end
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  g_ff <= '0;
                  if (req.kind == KIND_ALLOC) begin
                     need_ff <= need_in;
                     if (req.request_bytes == '0) begin
                        rsp_strobe <= 1'b1;
                        rsp        <= '{status: ST_NULL, payload_offset: '0};
                     end else begin
                        state_ff <= S_SCAN_RD;
                     end
                  end else begin
                     tgt_ff <= ADDR_W'(rel_gran - 12'(HEADER_GRANULES));
                     if (req.release_offset[GRANULE_SHIFT-1:0] != '0 ||
                         rel_gran < 12'(HEADER_GRANULES)) begin
                        rsp_strobe <= 1'b1;
                        rsp        <= '{status: ST_NULL, payload_offset: '0};
                     end else begin
                        state_ff <= S_REL_RD;
                     end
                  end
               end
            end
            // Walk headers for the first free block that fits
            S_SCAN_RD: state_ff <= (g_ff >= 14'(heap_end_ff)) ? S_GROW : S_SCAN_CHK;
            S_SCAN_CHK: begin
               if (ram_rdata.free && 14'(ram_rdata.size) >= need_ff) begin
                  at_ff    <= g_ff[ADDR_W-1:0];
                  cur_ff   <= ram_rdata;
                  state_ff <= S_TAKE;
               end else begin
                  g_ff     <= 14'(g_ff + 14'(HEADER_GRANULES) + 14'(ram_rdata.size));
                  state_ff <= S_SCAN_RD;
               end
            end
            // Append a new free block at the heap end, or report out of memory
            S_GROW: begin
               if (heap_end_ff > limit_eff || want > 14'(limit_eff - heap_end_ff)) begin
                  rsp_strobe <= 1'b1;
                  rsp        <= '{status: ST_OOM, payload_offset: '0};
                  state_ff   <= S_IDLE;
               end else begin
                  at_ff       <= heap_end_ff[ADDR_W-1:0];
                  cur_ff      <= '{size: GRAN_W'(want - 14'(HEADER_GRANULES)), free: 1'b1,
                                   prev: (heap_end_ff != '0) ? last_ff : '0};
                  last_ff     <= heap_end_ff[ADDR_W-1:0];
                  heap_end_ff <= GRAN_W'(14'(heap_end_ff) + want);
                  state_ff    <= S_TAKE;
               end
            end
            // Split off the remainder when it holds a header plus a granule
            S_TAKE: begin
               split_ff <= (14'(cur_ff.size) >= need_ff + 14'(HEADER_GRANULES + 1));
               state_ff <= S_TAKE_WR;
               if (14'(cur_ff.size) >= need_ff + 14'(HEADER_GRANULES + 1)) begin
                  nx_ff <= 14'(14'(at_ff) + 14'(HEADER_GRANULES) + 14'(cur_ff.size));
                  if (14'(14'(at_ff) + 14'(HEADER_GRANULES) + 14'(cur_ff.size))
                      < 14'(heap_end_ff)) begin
                     state_ff <= S_SPLIT_RDN;
                  end else begin
                     last_ff <= rest;
                  end
               end
            end
            S_SPLIT_RDN: state_ff <= S_SPLIT_WRN;
            S_SPLIT_WRN: state_ff <= S_TAKE_WR;
            S_TAKE_WR: begin
               rsp_strobe <= 1'b1;
               rsp        <= '{status: ST_DONE,
                               payload_offset: 16'((17'(at_ff) + 17'(HEADER_GRANULES))
                                                   << GRANULE_SHIFT)};
               state_ff   <= S_IDLE;
            end
            // Walk headers to confirm the released block exists and is in use
            S_REL_RD: begin
               if (g_ff >= 14'(heap_end_ff) || g_ff > 14'(tgt_ff)) begin
                  rsp_strobe <= 1'b1;
                  rsp        <= '{status: ST_NULL, payload_offset: '0};
                  state_ff   <= S_IDLE;
               end else begin
                  state_ff <= S_REL_CHK;
               end
            end
            S_REL_CHK: begin
               if (g_ff == 14'(tgt_ff)) begin
                  cur_ff <= ram_rdata;
                  if (ram_rdata.free) begin
                     rsp_strobe <= 1'b1;
                     rsp        <= '{status: ST_NULL, payload_offset: '0};
                     state_ff   <= S_IDLE;
                  end else begin
                     state_ff <= S_REL_MARK;
                  end
               end else begin
                  g_ff     <= 14'(g_ff + 14'(HEADER_GRANULES) + 14'(ram_rdata.size));
                  state_ff <= S_REL_RD;
               end
            end
            S_REL_MARK: begin
               b_ff     <= tgt_ff;
               phase_ff <= 1'b0;
               state_ff <= S_M_RDB;
            end
            // Merge block b with a free next block
            S_M_RDB: state_ff <= S_M_GETB;
            S_M_GETB: begin
               bhdr_ff  <= ram_rdata;
               nx_ff    <= 14'(14'(b_ff) + 14'(HEADER_GRANULES) + 14'(ram_rdata.size));
               state_ff <= S_M_RDN;
            end
            S_M_RDN: state_ff <= (nx_ff >= 14'(heap_end_ff)) ? S_M_DONE : S_M_GETN;
            S_M_GETN: begin
               if (ram_rdata.free) begin
                  bhdr_ff.size <= merged_size;
                  nx_ff    <= 14'(14'(b_ff) + 14'(HEADER_GRANULES) + 14'(merged_size));
                  state_ff <= S_M_RDN2;
               end else begin
                  state_ff <= S_M_DONE;
               end
            end
            S_M_RDN2: begin
               if (nx_ff >= 14'(heap_end_ff)) begin
                  last_ff  <= b_ff;
                  state_ff <= S_M_DONE;
               end else begin
                  state_ff <= S_M_GETN2;
               end
            end
            S_M_GETN2: state_ff <= S_M_DONE;
            // Then fold the released block into a free predecessor
            S_M_DONE: begin
               if (!phase_ff && tgt_ff != '0) begin
                  state_ff <= S_P_RD;
               end else begin
                  rsp_strobe <= 1'b1;
                  rsp        <= '{status: ST_DONE, payload_offset: '0};
                  state_ff   <= S_IDLE;
               end
            end
            S_P_RD: state_ff <= S_P_CHK;
            S_P_CHK: begin
               if (ram_rdata.free) begin
                  b_ff     <= cur_ff.prev;
                  phase_ff <= 1'b1;
                  state_ff <= S_M_RDB;
               end else begin
                  rsp_strobe <= 1'b1;
                  rsp        <= '{status: ST_DONE, payload_offset: '0};
                  state_ff   <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// ===== hdl/ffha_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ffha_ram #(
   parameter int WIDTH = 26,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
